// ===== design/assert_macros.svh =====
// assertion macros used by the sample player core
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ISP_ASSERT(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ISP_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ISP_ASSERT(name, clk, rstn, prop, msg)
`define ISP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== design/isp_pkg.sv =====
// types, codes and constants of the interpolating sample player
// no dependencies; used by every module of the block
package isp_pkg;

	localparam int MEM_DEPTH_DEF = 65536;
	localparam int FRAC_BITS_DEF = 16;
	localparam int FRAC_MAX      = 24;
	localparam int INC_MAX_W     = FRAC_MAX + 2;

	localparam int SPEED_W  = 7;
	localparam int GAIN_W   = 16;
	localparam int LEN_W    = 17;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 17;
	localparam int ADDR_IN_W = 16;
	localparam int SPEED_CODES = 128;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

	typedef enum logic [1:0] {
		REG_SPEED  = 2'd0,
		REG_GAIN   = 2'd1,
		REG_LENGTH = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_TRIGGER = 2'd1,
		FUNC_WRITE   = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]                 func;
		logic [ADDR_IN_W-1:0]       write_address;
		logic signed [SAMPLE_W-1:0] write_value;
	} isp_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] audio_out;
		logic                       playing;
	} isp_out_t;

	typedef logic [SPEED_CODES-1:0][INC_MAX_W-1:0] inc_tab_t;

	// increment per speed code: half + round(3*code*half/127), ties up
	function automatic inc_tab_t build_inc_tab(input int frac);
		inc_tab_t tab;
		longint   half;
		longint   inc;
		half = longint'(1) << (frac - 1);
		for (int c = 0; c < SPEED_CODES; c++) begin
			inc = half + (3 * longint'(c) * half + 63) / 127;
			tab[c] = INC_MAX_W'(inc);
		end
		return tab;
	endfunction

endpackage

// ===== design/isp_sample_mem.sv =====
// sample word memory, one write port and one registered read port
// uses isp_pkg for the sample width
module isp_sample_mem import isp_pkg::*; #(
	parameter int DEPTH = MEM_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic signed [SAMPLE_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic signed [SAMPLE_W-1:0] rdata
);

	logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/isp_mul.sv =====
// shared signed multiplier with registered product
// uses isp_pkg for the coefficient width
module isp_mul import isp_pkg::*; #(
	parameter int A_W = FRAC_BITS_DEF + 17
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [A_W-1:0]   a,
	input  logic signed [LEN_W-1:0] b,
	output logic signed [A_W+LEN_W-1:0] prod
);

	logic signed [A_W+LEN_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

// ===== design/interpolating_sample_player_core.sv =====
// interpolating sample player: a taken tick steps through RD0, RD1, MULD, SUM, MULG and FIN,
// a silent tick (past the end) goes straight to FIN; no new request is taken until idle,
// as the sequencer shares one multiplier and one memory read port; FIN waits for a free output.
// writes and triggers are taken one per cycle while the sequencer is idle.
// arst_n clears the sequencer, position, trigger flag and registers (speed 0,
// gain unity, length 0) at once; the sample memory is not cleared.
`include "assert_macros.svh"

module interpolating_sample_player_core import isp_pkg::*; #(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  isp_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output isp_out_t         out_data
);

	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int POS_W  = LEN_W + FRAC_BITS + 1;
	localparam int N_W    = POS_W - FRAC_BITS;
	localparam int V_W    = SAMPLE_W + FRAC_BITS + 1;
	localparam int PROD_W = V_W + LEN_W;
	localparam int R_W    = PROD_W - FRAC_BITS - 15;
	localparam inc_tab_t INC_TAB = build_inc_tab(FRAC_BITS);
	localparam logic [PROD_W-1:0] ROUND_K = PROD_W'(1) << (FRAC_BITS + 14);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD0  = 7'b0000010,
		ST_RD1  = 7'b0000100,
		ST_MULD = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_MULG = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [SPEED_W-1:0] speed_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [LEN_W-1:0]   len_q;

	logic [POS_W-1:0]           pos_q;
	logic                       trigger_q;
	logic [N_W-1:0]             n_q;
	logic [FRAC_BITS-1:0]       f_q;
	logic                       use_x1_q;
	logic                       silent_q;
	logic signed [SAMPLE_W-1:0] x0_q;
	logic signed [V_W-1:0]      v_q;

	logic     out_valid_q;
	isp_out_t out_q;

	logic                 in_acc;
	logic                 out_free;
	logic [POS_W-1:0]     pos_eff;
	logic [POS_W-1:0]     len_fix;
	logic                 silent;
	logic [N_W-1:0]       n_nx;
	logic                 use_x1_nx;
	logic [POS_W-1:0]     inc;

	logic                       mem_we;
	logic                       mem_re;
	logic [ADDR_W-1:0]          mem_raddr;
	logic signed [SAMPLE_W-1:0] mem_rdata;

	logic                       mul_en;
	logic signed [V_W-1:0]      mul_a;
	logic signed [LEN_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]   mul_prod;

	logic signed [SAMPLE_W-1:0] x1;
	logic signed [LEN_W-1:0]    diff;
	logic signed [V_W-1:0]      x0_w;
	logic [PROD_W-1:0]          rnd;
	logic signed [R_W-1:0]      r;
	logic signed [SAMPLE_W-1:0] sat;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// position seen by this tick and its split into index and fraction
	assign pos_eff   = trigger_q ? '0 : pos_q;
	assign len_fix   = POS_W'(len_q) << FRAC_BITS;
	assign silent    = !trigger_q && (pos_q >= len_fix);
	assign n_nx      = pos_eff[POS_W-1:FRAC_BITS];
	assign use_x1_nx = !trigger_q &&
		(((N_W+1)'(n_nx) + (N_W+1)'(1)) < (N_W+1)'(len_q));
	assign inc       = POS_W'(INC_TAB[speed_q]);

	assign mem_we = in_acc && (in_data.func == FUNC_WRITE);
	assign mem_re = (state_q == ST_RD0) || (state_q == ST_RD1);
	assign mem_raddr = (state_q == ST_RD1) ? ADDR_W'(n_q + N_W'(1)) : ADDR_W'(n_q);

	isp_sample_mem #(
		.DEPTH(MEM_DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(ADDR_W'(in_data.write_address)),
		.wdata(in_data.write_value),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign x1   = use_x1_q ? mem_rdata : x0_q;
	assign diff = {x1[SAMPLE_W-1], x1} - {x0_q[SAMPLE_W-1], x0_q};
	assign x0_w = V_W'(x0_q);

	always_comb begin
		mul_en = 1'b0;
		mul_a  = v_q;
		mul_b  = signed'({1'b0, gain_q});
		case (state_q)
			ST_MULD: begin
				mul_en = 1'b1;
				mul_a  = signed'(V_W'(f_q));
				mul_b  = diff;
			end
			ST_MULG: begin
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	isp_mul #(
		.A_W(V_W)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.prod(mul_prod)
	);

	// round, scale back to Q1.15 and saturate
	assign rnd = mul_prod + ROUND_K;
	assign r   = signed'(rnd[PROD_W-1:FRAC_BITS+15]);
	always_comb begin
		if (r > R_W'(32767)) begin
			sat = 16'sh7fff;
		end else if (r < -R_W'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = SAMPLE_W'(r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			gain_q  <= GAIN_RESET;
			len_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED:  speed_q <= cfg_wdata[SPEED_W-1:0];
				REG_GAIN:   gain_q  <= cfg_wdata[GAIN_W-1:0];
				REG_LENGTH: len_q   <= cfg_wdata[LEN_W-1:0];
				default:    speed_q <= speed_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			trigger_q   <= 1'b0;
			silent_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_data.func)
							FUNC_TICK: begin
								trigger_q <= 1'b0;
								silent_q  <= silent;
								if (silent) begin
									state_q <= ST_FIN;
								end else begin
									pos_q   <= pos_eff + inc;
									state_q <= ST_RD0;
								end
							end
							FUNC_TRIGGER: begin
								trigger_q <= 1'b1;
							end
							default: begin
								trigger_q <= trigger_q;
							end
						endcase
					end
				end
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_MULD;
				ST_MULD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_MULG;
				ST_MULG: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q      <= n_nx;
			f_q      <= pos_eff[FRAC_BITS-1:0];
			use_x1_q <= use_x1_nx;
		end
		if (state_q == ST_RD1) begin
			x0_q <= mem_rdata;
		end
		if (state_q == ST_SUM) begin
			v_q <= (x0_w <<< FRAC_BITS) + mul_prod[V_W-1:0];
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q.audio_out <= silent_q ? '0 : sat;
			out_q.playing   <= !silent_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ISP_ASSERT(a_fin_loads_out, clk, arst_n, (state_q == ST_FIN) && out_free |=> out_valid && (state_q == ST_IDLE), "finished tick did not reach the output register")
	`ISP_ASSERT(a_tick_clears_trigger, clk, arst_n, in_acc && (in_data.func == FUNC_TICK) |=> !trigger_q, "trigger still pending after a tick")
	`ISP_ASSERT(a_silent_is_zero, clk, arst_n, out_valid && !out_data.playing |-> out_data.audio_out == '0, "silent result carries nonzero audio")
	`ISP_ASSERT(a_busy_no_write, clk, arst_n, (state_q != ST_IDLE) |-> !mem_we, "sample write while a tick is in progress")

endmodule

// ===== test/tb_interpolating_sample_player_core.sv =====
// self-checking testbench of interpolating_sample_player_core: a directed table, then random
// requests under three idle patterns, checked against table values or an in-bench playback predictor
// depends on isp_pkg and the core only
module tb_interpolating_sample_player_core;
	import isp_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int DEPTH = MEM_DEPTH_DEF;
	localparam logic [1:0] FUNC_IGNORED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_SETTING = 100;
	localparam int CONFIGS_PER_PHASE = 4;
	localparam int MAX_REPORTS = 10;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_CHECK,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [1:0]       sel;
		logic [15:0]      addr;
		logic [CFG_W-1:0] data;
		isp_out_t         want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	isp_in_t          in_data;
	logic             out_valid;
	logic             out_stall;
	isp_out_t         out_data;

	// predictor state
	logic signed [SAMPLE_W-1:0] sample_mem [DEPTH];
	bit                         written_mem [DEPTH];
	longint unsigned            play_pos;
	bit                         trig_pend;
	logic [SPEED_W-1:0]         play_speed;
	logic [GAIN_W-1:0]          play_gain;
	logic [LEN_W-1:0]           play_len;

	isp_out_t expected_q [$];
	isp_out_t want_res;
	dir_row_t stim_tab [$];
	int       fail_cnt = 0;
	int       report_cnt = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       idle_cycles = 0;

	interpolating_sample_player_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned step_inc();
		longint unsigned half;
		longint unsigned sp;
		half = longint'(1) << (FRAC - 1);
		sp = play_speed;
		return half + (3 * sp * half + 63) / 127;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] scale_gain(input longint v);
		longint g;
		longint p;
		longint r;
		g = play_gain;
		p = v * g + (longint'(1) <<< (FRAC + 14));
		r = p >>> (FRAC + 15);
		if (r > 32767) begin
			r = 32767;
		end else if (r < -32768) begin
			r = -32768;
		end
		return r[SAMPLE_W-1:0];
	endfunction

	// address a tick would read before it was ever written, or -1
	function automatic int unread_addr();
		longint unsigned n;
		if (trig_pend) begin
			return written_mem[0] ? -1 : 0;
		end
		if (play_pos >= (longint'(play_len) << FRAC)) begin
			return -1;
		end
		n = play_pos >> FRAC;
		if (!written_mem[n % DEPTH]) begin
			return int'(n % DEPTH);
		end
		if (n + 1 < play_len && !written_mem[(n + 1) % DEPTH]) begin
			return int'((n + 1) % DEPTH);
		end
		return -1;
	endfunction

	function automatic bit predict_step(input isp_in_t req, output isp_out_t res);
		longint unsigned n;
		longint f;
		longint x0;
		longint x1;
		longint v;
		res = '0;
		if (req.func == FUNC_TRIGGER) begin
			trig_pend = 1'b1;
			return 1'b0;
		end
		if (req.func == FUNC_WRITE) begin
			sample_mem[req.write_address] = req.write_value;
			written_mem[req.write_address] = 1'b1;
			return 1'b0;
		end
		if (req.func != FUNC_TICK) begin
			return 1'b0;
		end
		// restart outputs sample 0 itself
		if (trig_pend) begin
			trig_pend = 1'b0;
			play_pos = step_inc();
			x0 = sample_mem[0];
			res.audio_out = scale_gain(x0 <<< FRAC);
			res.playing = 1'b1;
			return 1'b1;
		end
		// past the end: silence, position holds
		if (play_pos >= (longint'(play_len) << FRAC)) begin
			return 1'b1;
		end
		n = play_pos >> FRAC;
		f = play_pos & ((longint'(1) << FRAC) - 1);
		x0 = sample_mem[n % DEPTH];
		if (n + 1 < play_len) begin
			x1 = sample_mem[(n + 1) % DEPTH];
		end else begin
			x1 = x0;
		end
		v = (x0 <<< FRAC) + (x1 - x0) * f;
		play_pos += step_inc();
		res.audio_out = scale_gain(v);
		res.playing = 1'b1;
		return 1'b1;
	endfunction

	function automatic dir_row_t row_item(input logic [1:0] sel, input logic [15:0] addr,
			input logic [15:0] value);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.sel = sel;
		r.addr = addr;
		r.data = {1'b0, value};
		return r;
	endfunction

	function automatic dir_row_t row_check(input logic [1:0] sel,
			input logic signed [SAMPLE_W-1:0] audio, input logic playing);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CHECK;
		r.sel = sel;
		r.want.audio_out = audio;
		r.want.playing = playing;
		return r;
	endfunction

	function automatic dir_row_t row_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.sel = idx;
		r.data = value;
		return r;
	endfunction

	task automatic send_req(input isp_in_t req, input bit use_typed, input isp_out_t typed_res);
		isp_out_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		if (predict_step(req, res)) begin
			expected_q.push_back(use_typed ? typed_res : res);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_SPEED:  play_speed = value[SPEED_W-1:0];
			REG_GAIN:   play_gain = value[GAIN_W-1:0];
			REG_LENGTH: play_len = value[LEN_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int slot);
		logic [CFG_W-1:0] value;
		value = CFG_W'($urandom());
		case ($urandom_range(2))
			0: value[SPEED_W-1:0] = '0;
			1: value[SPEED_W-1:0] = '1;
			default: ;
		endcase
		cfg_write(REG_SPEED, value);
		value = CFG_W'($urandom());
		case ($urandom_range(3))
			0: value[GAIN_W-1:0] = '0;
			1: value[GAIN_W-1:0] = GAIN_RESET;
			2: value[GAIN_W-1:0] = '1;
			default: ;
		endcase
		cfg_write(REG_GAIN, value);
		case (slot % 6)
			0: value = 17'd1;
			1: value = 17'd65536;
			2: value = 17'h1ffff;
			3: value = 17'd0;
			default: value = CFG_W'($urandom_range(24, 2));
		endcase
		cfg_write(REG_LENGTH, value);
		cfg_write(REG_UNUSED, CFG_W'($urandom()));
	endtask

	task automatic run_random(input int count);
		isp_in_t  req;
		isp_out_t none;
		int       pick;
		int       miss;
		int       done;
		none = '0;
		done = 0;
		while (done < count) begin
			req.write_address = 16'($urandom());
			req.write_value = 16'($urandom());
			case ($urandom_range(9))
				0: req.write_value = 16'sh8000;
				1: req.write_value = 16'sh7fff;
				default: ;
			endcase
			pick = $urandom_range(99);
			if (pick < 55) begin
				req.func = FUNC_TICK;
			end else if (pick < 63) begin
				req.func = FUNC_TRIGGER;
			end else if (pick < 97) begin
				req.func = FUNC_WRITE;
				if ($urandom_range(9) < 7) begin
					req.write_address = 16'($urandom_range(255));
				end
			end else begin
				req.func = FUNC_IGNORED;
			end
			// fill the word a tick would need first
			if (req.func == FUNC_TICK) begin
				miss = unread_addr();
				if (miss >= 0) begin
					req.func = FUNC_WRITE;
					req.write_address = 16'(miss);
				end
			end
			send_req(req, 1'b0, none);
			if (req.func != FUNC_IGNORED) begin
				done++;
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				fail_cnt++;
				if (report_cnt < MAX_REPORTS) begin
					$display("unexpected result: audio %0d playing %0b",
						out_data.audio_out, out_data.playing);
				end
				report_cnt++;
			end else begin
				want_res = expected_q.pop_front();
				if (out_data.audio_out !== want_res.audio_out
						|| out_data.playing !== want_res.playing) begin
					fail_cnt++;
					if (report_cnt < MAX_REPORTS) begin
						$display("mismatch: expected audio %0d playing %0b, got audio %0d playing %0b",
							want_res.audio_out, want_res.playing,
							out_data.audio_out, out_data.playing);
					end
					report_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("interpolating_sample_player_core regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		isp_in_t req;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		play_pos = 0;
		trig_pend = 1'b0;
		play_speed = '0;
		play_gain = GAIN_RESET;
		play_len = '0;

		stim_tab.push_back(row_check(FUNC_TICK, 16'sh0000, 1'b0));
		stim_tab.push_back(row_item(FUNC_WRITE, 16'h0000, 16'h8000));
		stim_tab.push_back(row_item(FUNC_IGNORED, 16'hffff, 16'h7fff));
		stim_tab.push_back(row_item(FUNC_TRIGGER, 16'h0000, 16'h0000));
		stim_tab.push_back(row_item(FUNC_TRIGGER, 16'h0000, 16'h0000));
		stim_tab.push_back(row_check(FUNC_TICK, 16'sh8000, 1'b1));
		stim_tab.push_back(row_check(FUNC_TICK, 16'sh0000, 1'b0));
		stim_tab.push_back(row_cfg(REG_LENGTH, 17'd4));
		stim_tab.push_back(row_item(FUNC_WRITE, 16'h0001, 16'h7fff));
		stim_tab.push_back(row_item(FUNC_WRITE, 16'h0002, 16'h0000));
		stim_tab.push_back(row_item(FUNC_WRITE, 16'h0003, 16'h1234));
		stim_tab.push_back(row_item(FUNC_WRITE, 16'hffff, 16'h7fff));
		stim_tab.push_back(row_item(FUNC_TRIGGER, 16'h0000, 16'h0000));
		stim_tab.push_back(row_check(FUNC_TICK, 16'sh8000, 1'b1));
		repeat (7) stim_tab.push_back(row_item(FUNC_TICK, 16'h0000, 16'h0000));
		stim_tab.push_back(row_check(FUNC_TICK, 16'sh0000, 1'b0));
		stim_tab.push_back(row_cfg(REG_SPEED, 17'd127));
		stim_tab.push_back(row_cfg(REG_GAIN, 17'd0));
		stim_tab.push_back(row_item(FUNC_TRIGGER, 16'h0000, 16'h0000));
		stim_tab.push_back(row_check(FUNC_TICK, 16'sh0000, 1'b1));
		stim_tab.push_back(row_cfg(REG_GAIN, 17'hffff));
		stim_tab.push_back(row_item(FUNC_TRIGGER, 16'h0000, 16'h0000));
		stim_tab.push_back(row_check(FUNC_TICK, 16'sh8000, 1'b1));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tab[i]) begin
			if (stim_tab[i].kind == ROW_CFG) begin
				settle();
				cfg_write(stim_tab[i].sel, stim_tab[i].data);
			end else begin
				req.func = stim_tab[i].sel;
				req.write_address = stim_tab[i].addr;
				req.write_value = stim_tab[i].data[SAMPLE_W-1:0];
				send_req(req, stim_tab[i].kind == ROW_CHECK, stim_tab[i].want);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 21;
					recv_stall_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_stall_pct = 21;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int c = 0; c < CONFIGS_PER_PHASE; c++) begin
				settle();
				apply_setting(phase * CONFIGS_PER_PHASE + c);
				run_random(ITEMS_PER_SETTING);
			end
		end

		settle();
		if (fail_cnt == 0 && expected_q.size() == 0) begin
			$display("interpolating_sample_player_core regression: pass");
		end else begin
			$display("interpolating_sample_player_core regression: fail");
		end
		$finish;
	end

endmodule
